/* hdl/vaf_pkg.sv */
// Shared types, codes and helpers of the single-window VCDIFF add-only framer.
`default_nettype none

package vaf_pkg;

  localparam int LEN_W           = 28;
  localparam int CAP_W           = 32;
  localparam int DLEN_W          = 29;
  localparam int CNT_W           = 3;
  localparam int LENGTH_BITS_DEF = 28;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  localparam logic CFG_TARGET_LENGTH   = 1'b0;
  localparam logic CFG_OUTPUT_CAPACITY = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CAPACITY = 2'd1;
  localparam logic [1:0] ST_OUTSIDE  = 2'd2;

  localparam logic [7:0] MAGIC_0    = 8'hD6;
  localparam logic [7:0] MAGIC_1    = 8'hC3;
  localparam logic [7:0] MAGIC_2    = 8'hC4;
  localparam logic [7:0] BYTE_ZERO  = 8'h00;
  localparam logic [7:0] BYTE_ADD   = 8'h01;
  localparam logic [7:0] DIGIT_MASK = 8'h7F;
  localparam logic [7:0] CONT_BIT   = 8'h80;

  typedef enum logic [2:0] {
    K_START,
    K_START_ZERO,
    K_CAP_ERR,
    K_OUTSIDE,
    K_DATA,
    K_DATA_LAST
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         data;
    logic [LEN_W-1:0]   len;
    logic [DLEN_W-1:0]  dlen;
    logic [CNT_W-1:0]   vn;
    logic [CNT_W-1:0]   vd;
  } entry_t;

  // Number of base-128 digits of a value below 2^32.
  function automatic logic [CNT_W-1:0] vsize(logic [31:0] v);
    vsize = CNT_W'(1) + CNT_W'(v >= 32'h0000_0080) + CNT_W'(v >= 32'h0000_4000)
          + CNT_W'(v >= 32'h0020_0000) + CNT_W'(v >= 32'h1000_0000);
  endfunction

endpackage

`default_nettype wire

/* hdl/vcdiff_add_only_framer.sv */
// Top level of the single-window VCDIFF add-only framer.
// Wraps a target byte stream of known length into a one-window VCDIFF delta with one ADD
// instruction. An item is accepted in every cycle while the command queue has room. A data
// byte gives one output byte; a start item gives a burst of 9 + size(dlen) +
// 2*size(len) bytes (plus 1 + size(len) trailer bytes for a zero length), and the last data
// byte of a frame gives 2 + size(len) bytes. While the output accepts, the byte sequencer emits
// one byte per cycle; during a burst the front keeps accepting until the QUEUE_DEPTH-entry
// queue fills. An item passes the input register, the queue and the output register in turn.
`default_nettype none

module vcdiff_add_only_framer #(
  parameter int LENGTH_BITS = vaf_pkg::LENGTH_BITS_DEF,
  parameter int QUEUE_DEPTH = vaf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,   // [0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,
  output logic [2:0]  m_axis_tuser    // [1:0] status, [2] frame_end
);
  import vaf_pkg::*;

  entry_t push_entry, head;
  logic   push, pop, full, empty;

  assign cfg_ready_o = 1'b1;

  vaf_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .s_opcode_i (s_axis_tuser[0]),
    .s_data_i   (s_axis_tdata),
    .q_full_i   (full),
    .q_push_o   (push),
    .q_entry_o  (push_entry)
  );

  vaf_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .pop_i  (pop),
    .full_o (full),
    .empty_o(empty),
    .head_o (head)
  );

  vaf_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .empty_i   (empty),
    .head_i    (head),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_byte_o  (m_axis_tdata),
    .m_status_o(m_axis_tuser[1:0]),
    .m_last_o  (m_axis_tlast),
    .m_fend_o  (m_axis_tuser[2])
  );

endmodule

`default_nettype wire

/* hdl/vaf_front.sv */
// Front end: configuration registers, size computation, frame tracking and item classification.
`default_nettype none

module vaf_front #(
  parameter int LENGTH_BITS = vaf_pkg::LENGTH_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  logic                s_opcode_i,
  input  logic [7:0]          s_data_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output vaf_pkg::entry_t     q_entry_o
);
  import vaf_pkg::*;

  localparam logic [LEN_W-1:0] LenMask = (LENGTH_BITS >= LEN_W) ? {LEN_W{1'b1}} :
                                         LEN_W'((64'd1 << LENGTH_BITS) - 64'd1);

  logic [LEN_W-1:0]       target_q;
  logic [CAP_W-1:0]       cap_q;
  logic [LEN_W-1:0]       len;
  logic [CNT_W-1:0]       vn;
  logic [DLEN_W-1:0]      dlen;
  logic                   accept;

  logic                   a_valid_q;
  logic                   a_op_q;
  logic [7:0]             a_data_q;
  logic [LEN_W-1:0]       a_len_q;
  logic [CNT_W-1:0]       a_vn_q;
  logic [DLEN_W-1:0]      a_dlen_q;

  logic                   frame_active_q, frame_active_d;
  logic [LENGTH_BITS-1:0] bytes_seen_q, bytes_seen_d;
  logic [LENGTH_BITS-1:0] seen_inc;
  logic [CNT_W-1:0]       vd;
  logic [CAP_W:0]         total;
  logic                   cap_err;
  logic                   reached;
  kind_e                  kind;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      cap_q    <= '1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_TARGET_LENGTH) target_q <= cfg_data_i[LEN_W-1:0];
      else                                  cap_q    <= cfg_data_i;
    end
  end

  assign len    = target_q & LenMask;
  assign vn     = vsize(32'(len));
  // dlen = len + 3*vn + 4
  assign dlen   = DLEN_W'(len) + DLEN_W'({vn, 1'b0}) + DLEN_W'(vn) + DLEN_W'(4);

  assign s_ready_o = !a_valid_q || !q_full_i;
  assign accept    = s_valid_i && s_ready_o;
  assign q_push_o  = a_valid_q && !q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (accept) begin
      a_valid_q <= 1'b1;
    end else if (q_push_o) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_op_q   <= s_opcode_i;
      a_data_q <= s_data_i;
      a_len_q  <= len;
      a_vn_q   <= vn;
      a_dlen_q <= dlen;
    end
  end

  assign vd       = vsize(32'(a_dlen_q));
  assign total    = (CAP_W+1)'(a_dlen_q) + (CAP_W+1)'(vd) + (CAP_W+1)'(6);
  assign cap_err  = total > (CAP_W+1)'(cap_q);
  assign seen_inc = bytes_seen_q + LENGTH_BITS'(1);
  assign reached  = 32'(seen_inc) >= 32'(a_len_q);

  always_comb begin
    frame_active_d = frame_active_q;
    bytes_seen_d   = bytes_seen_q;
    kind           = K_OUTSIDE;
    if (a_op_q == OP_START) begin
      frame_active_d = 1'b0;
      bytes_seen_d   = '0;
      if (cap_err) begin
        kind = K_CAP_ERR;
      end else if (a_len_q == '0) begin
        kind = K_START_ZERO;
      end else begin
        kind           = K_START;
        frame_active_d = 1'b1;
      end
    end else if (!frame_active_q) begin
      kind = K_OUTSIDE;
    end else if (reached) begin
      kind           = K_DATA_LAST;
      frame_active_d = 1'b0;
      bytes_seen_d   = '0;
    end else begin
      kind         = K_DATA;
      bytes_seen_d = seen_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_active_q <= 1'b0;
      bytes_seen_q   <= '0;
    end else if (q_push_o) begin
      frame_active_q <= frame_active_d;
      bytes_seen_q   <= bytes_seen_d;
    end
  end

  always_comb begin
    q_entry_o.kind = kind;
    q_entry_o.data = a_data_q;
    q_entry_o.len  = a_len_q;
    q_entry_o.dlen = a_dlen_q;
    q_entry_o.vn   = a_vn_q;
    q_entry_o.vd   = vd;
  end

endmodule

`default_nettype wire

/* hdl/vaf_fifo.sv */
// Short command queue between the front end and the byte sequencer.
`default_nettype none

module vaf_fifo #(
  parameter int DEPTH = vaf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  vaf_pkg::entry_t  entry_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output vaf_pkg::entry_t  head_o
);
  import vaf_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  entry_t          mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  function automatic logic [PtrW-1:0] bump(logic [PtrW-1:0] p);
    bump = (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o  = count_q == CntW'(DEPTH);
  assign empty_o = count_q == '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= bump(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= bump(rd_ptr_q);
      if (push_i && !pop_i)      count_q <= count_q + CntW'(1);
      else if (pop_i && !push_i) count_q <= count_q - CntW'(1);
    end
  end

endmodule

`default_nettype wire

/* hdl/vaf_back.sv */
// Back end: byte sequencer that expands queued commands into output bytes, with output register.
`default_nettype none

module vaf_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  vaf_pkg::entry_t  head_i,
  output logic             pop_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  output logic [7:0]       m_byte_o,
  output logic [1:0]       m_status_o,
  output logic             m_last_o,
  output logic             m_fend_o
);
  import vaf_pkg::*;

  localparam logic [3:0] P_HDR  = 4'd0;
  localparam logic [3:0] P_VDL  = 4'd1;
  localparam logic [3:0] P_VL1  = 4'd2;
  localparam logic [3:0] P_Z1   = 4'd3;
  localparam logic [3:0] P_VL2  = 4'd4;
  localparam logic [3:0] P_INST = 4'd5;
  localparam logic [3:0] P_Z2   = 4'd6;
  localparam logic [3:0] P_T01  = 4'd7;
  localparam logic [3:0] P_VLT  = 4'd8;
  localparam logic [3:0] P_DATA = 4'd9;
  localparam logic [3:0] P_ERR  = 4'd10;

  logic             busy_q, busy_d;
  logic [3:0]       ph_q, ph_d;
  logic [2:0]       idx_q, idx_d;
  logic [3:0]       cph, nph;
  logic [2:0]       cidx, plen;
  logic             seg_end, entry_end, go;
  logic [7:0]       byte_n;
  logic [1:0]       status_n;

  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic [1:0]       out_status_q;
  logic             out_last_q, out_fend_q;

  function automatic logic [7:0] varint_byte(logic [31:0] v, logic [2:0] n, logic [2:0] i);
    logic [2:0] d;
    logic [6:0] dig;
    d = n - i - 3'd1;
    case (d)
      3'd0:    dig = v[6:0];
      3'd1:    dig = v[13:7];
      3'd2:    dig = v[20:14];
      3'd3:    dig = v[27:21];
      default: dig = {3'b000, v[31:28]};
    endcase
    varint_byte = ({1'b0, dig} & DIGIT_MASK) | ((i != n - 3'd1) ? CONT_BIT : BYTE_ZERO);
  endfunction

  always_comb begin
    if (busy_q) begin
      cph = ph_q;
    end else begin
      case (head_i.kind)
        K_START, K_START_ZERO: cph = P_HDR;
        K_DATA, K_DATA_LAST:   cph = P_DATA;
        default:               cph = P_ERR;
      endcase
    end
  end

  assign cidx = busy_q ? idx_q : 3'd0;

  always_comb begin
    case (cph)
      P_HDR:               plen = 3'd6;
      P_VDL:               plen = head_i.vd;
      P_VL1, P_VL2, P_VLT: plen = head_i.vn;
      default:             plen = 3'd1;
    endcase
  end

  assign seg_end = cidx == plen - 3'd1;

  always_comb begin
    nph       = cph;
    entry_end = 1'b0;
    case (cph)
      P_HDR:  nph = P_VDL;
      P_VDL:  nph = P_VL1;
      P_VL1:  nph = P_Z1;
      P_Z1:   nph = P_VL2;
      P_VL2:  nph = P_INST;
      P_INST: nph = P_Z2;
      P_Z2: begin
        nph       = P_T01;
        entry_end = seg_end && (head_i.kind != K_START_ZERO);
      end
      P_DATA: begin
        nph       = P_T01;
        entry_end = head_i.kind != K_DATA_LAST;
      end
      P_T01:  nph = P_VLT;
      default: entry_end = seg_end;
    endcase
  end

  always_comb begin
    status_n = ST_OK;
    case (cph)
      P_HDR: begin
        case (cidx)
          3'd0:    byte_n = MAGIC_0;
          3'd1:    byte_n = MAGIC_1;
          3'd2:    byte_n = MAGIC_2;
          default: byte_n = BYTE_ZERO;
        endcase
      end
      P_VDL:               byte_n = varint_byte(32'(head_i.dlen), head_i.vd, cidx);
      P_VL1, P_VL2, P_VLT: byte_n = varint_byte(32'(head_i.len), head_i.vn, cidx);
      P_INST:              byte_n = 8'(head_i.vn) + 8'd1;
      P_T01:               byte_n = BYTE_ADD;
      P_DATA:              byte_n = head_i.data;
      P_ERR: begin
        byte_n   = BYTE_ZERO;
        status_n = (head_i.kind == K_CAP_ERR) ? ST_CAPACITY : ST_OUTSIDE;
      end
      default:             byte_n = BYTE_ZERO;
    endcase
  end

  assign go    = !empty_i && (!out_valid_q || m_ready_i);
  assign pop_o = go && entry_end;

  always_comb begin
    busy_d = busy_q;
    ph_d   = ph_q;
    idx_d  = idx_q;
    if (go) begin
      busy_d = !entry_end;
      ph_d   = seg_end ? nph : cph;
      idx_d  = seg_end ? 3'd0 : cidx + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      ph_q        <= P_HDR;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      ph_q   <= ph_d;
      idx_q  <= idx_d;
      if (go)             out_valid_q <= 1'b1;
      else if (m_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      out_byte_q   <= byte_n;
      out_status_q <= status_n;
      out_last_q   <= entry_end;
      out_fend_q   <= (cph == P_VLT) && seg_end;
    end
  end

  assign m_valid_o  = out_valid_q;
  assign m_byte_o   = out_byte_q;
  assign m_status_o = out_status_q;
  assign m_last_o   = out_last_q;
  assign m_fend_o   = out_fend_q;

endmodule

`default_nettype wire

/* hdl/vaf_checker.sv */
// Port-level assertions for the framer, bound to the top level.
`default_nettype none

module vaf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [2:0]  m_axis_tuser
);
  import vaf_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output transaction changed while stalled");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[1:0] != ST_OK) |->
      m_axis_tlast && (m_axis_tdata == BYTE_ZERO) && !m_axis_tuser[2])
    else $error("error result not a lone zero byte");

  a_fend_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |->
      m_axis_tlast && (m_axis_tuser[1:0] == ST_OK) && !m_axis_tdata[7])
    else $error("frame end not on a closing varint byte");

endmodule

bind vcdiff_add_only_framer vaf_checker u_vaf_checker (.*);

`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for the single-window VCDIFF add-only framer.
`timescale 1ns / 1ps

module testbench;
  import vaf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int          RANDOM_ITEMS = 300;

  typedef struct packed {
    logic [7:0] value;
    logic [1:0] status;
    logic       run_last;
    logic       frame_end;
  } delta_byte_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic [0:0]  s_axis_tuser;   // [0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;   // [7:0] out_byte
  logic        m_axis_tlast;
  logic [2:0]  m_axis_tuser;   // [1:0] status, [2] frame_end

  // predictor state
  logic [LEN_W-1:0] len_reg;
  logic [31:0]      capacity_reg;
  logic             frame_open;
  logic [LEN_W-1:0] bytes_passed;

  delta_byte_t      delta_bytes_q[$];
  delta_byte_t      got_want;
  int unsigned      fail_count  = 0;
  int unsigned      cycle_count = 0;
  logic             calm        = 1'b0;

  vcdiff_add_only_framer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("testbench NOT OK");
    $finish;
  end

  initial begin : sink
    forever begin
      @(negedge clk_i);
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 32);
    end
  end

  // ---------------- predictor ----------------

  function automatic int digits(longint unsigned v);
    int n;
    n = 1;
    v = v >> 7;
    while (v != 0) begin
      n++;
      v = v >> 7;
    end
    return n;
  endfunction

  function automatic longint unsigned delta_len(longint unsigned len);
    longint unsigned vn;
    vn = digits(len);
    return vn + 1 + vn + digits(1 + vn) + 1 + len + (1 + vn);
  endfunction

  function automatic longint unsigned frame_total(longint unsigned len);
    longint unsigned dlen;
    dlen = delta_len(len);
    return 6 + digits(dlen) + dlen;
  endfunction

  function automatic void queue_byte(logic [7:0] v, logic [1:0] st, logic fe);
    delta_bytes_q.push_back('{value: v, status: st, run_last: 1'b0, frame_end: fe});
  endfunction

  function automatic void queue_varint(longint unsigned v, logic fe);
    int n;
    n = digits(v);
    for (int i = n - 1; i >= 0; i--)
      queue_byte((8'(v >> (7 * i)) & DIGIT_MASK) | ((i != 0) ? CONT_BIT : BYTE_ZERO),
                 ST_OK, (i == 0) ? fe : 1'b0);
  endfunction

  function automatic void queue_trailer(longint unsigned len);
    queue_byte(BYTE_ADD, ST_OK, 1'b0);
    queue_varint(len, 1'b1);
  endfunction

  function automatic void encode_item(logic op, logic [7:0] b);
    longint unsigned len;
    longint unsigned dlen;
    delta_byte_t     tail;
    len = longint'(len_reg);
    if (op == OP_START) begin
      dlen         = delta_len(len);
      frame_open   = 1'b0;
      bytes_passed = '0;
      if (frame_total(len) > longint'(capacity_reg)) begin
        queue_byte(BYTE_ZERO, ST_CAPACITY, 1'b0);
      end else begin
        queue_byte(MAGIC_0, ST_OK, 1'b0);
        queue_byte(MAGIC_1, ST_OK, 1'b0);
        queue_byte(MAGIC_2, ST_OK, 1'b0);
        queue_byte(BYTE_ZERO, ST_OK, 1'b0);
        queue_byte(BYTE_ZERO, ST_OK, 1'b0);
        queue_byte(BYTE_ZERO, ST_OK, 1'b0);
        queue_varint(dlen, 1'b0);
        queue_varint(len, 1'b0);
        queue_byte(BYTE_ZERO, ST_OK, 1'b0);
        queue_varint(len, 1'b0);
        queue_varint(1 + digits(len), 1'b0);
        queue_byte(BYTE_ZERO, ST_OK, 1'b0);
        if (len == 0) queue_trailer(len);
        else          frame_open = 1'b1;
      end
    end else if (!frame_open) begin
      queue_byte(BYTE_ZERO, ST_OUTSIDE, 1'b0);
    end else begin
      queue_byte(b, ST_OK, 1'b0);
      bytes_passed = bytes_passed + 1'b1;
      if (bytes_passed >= len_reg) begin
        queue_trailer(len);
        frame_open   = 1'b0;
        bytes_passed = '0;
      end
    end
    tail = delta_bytes_q.pop_back();
    tail.run_last = 1'b1;
    delta_bytes_q.push_back(tail);
  endfunction

  // ---------------- checker ----------------

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (delta_bytes_q.size() == 0) begin
        $error("unexpected output byte %h", m_axis_tdata);
        fail_count++;
      end else begin
        got_want = delta_bytes_q.pop_front();
        if (m_axis_tdata !== got_want.value) begin
          $error("out_byte: expected %h, got %h", got_want.value, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tuser[1:0] !== got_want.status) begin
          $error("status: expected %0d, got %0d", got_want.status, m_axis_tuser[1:0]);
          fail_count++;
        end
        if (m_axis_tlast !== got_want.run_last) begin
          $error("run_last: expected %0b, got %0b", got_want.run_last, m_axis_tlast);
          fail_count++;
        end
        if (m_axis_tuser[2] !== got_want.frame_end) begin
          $error("frame_end: expected %0b, got %0b", got_want.frame_end, m_axis_tuser[2]);
          fail_count++;
        end
      end
    end
  end

  // ---------------- drivers ----------------

  task automatic push_item(logic op, logic [7:0] b);
    while (!calm && $urandom_range(0, 99) < 32) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    encode_item(op, b);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (delta_bytes_q.size() != 0) @(negedge clk_i);
  endtask

  // writes both registers once all expected output has drained
  task automatic configure(logic [31:0] len_v, logic [31:0] cap_v);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_TARGET_LENGTH;
    cfg_data_i  <= len_v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    len_reg = len_v[LEN_W-1:0];
    @(negedge clk_i);
    cfg_index_i <= CFG_OUTPUT_CAPACITY;
    cfg_data_i  <= cap_v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    capacity_reg = cap_v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------- tests ----------------

  task automatic test_zero_length();
    push_item(OP_START, 8'h00);
    push_item(OP_DATA, 8'h5A);
  endtask

  task automatic test_pass_through();
    configure(32'd3, '1);
    push_item(OP_START, 8'hFF);
    push_item(OP_DATA, 8'h00);
    push_item(OP_DATA, 8'hFF);
    push_item(OP_DATA, 8'hA5);
  endtask

  task automatic test_varint_widths();
    logic [31:0] lens[6];
    lens = '{32'd127, 32'd128, 32'd16383, 32'd16384, 32'd2097152, 32'hFFFF_FFFF};
    foreach (lens[i]) begin
      configure(lens[i], '1);
      push_item(OP_START, 8'h00);
    end
  endtask

  task automatic test_capacity();
    configure(32'd5, 32'(frame_total(5) - 1));
    push_item(OP_START, 8'h00);
    push_item(OP_DATA, 8'h11);
    configure(32'd5, 32'(frame_total(5)));
    push_item(OP_START, 8'h00);
    configure(32'd0, 32'd0);
    push_item(OP_START, 8'h00);
  endtask

  task automatic test_restart_open_frame();
    configure(32'd2, '1);
    push_item(OP_START, 8'h00);
    push_item(OP_DATA, 8'h81);
    push_item(OP_START, 8'h00);
    push_item(OP_DATA, 8'h7E);
    push_item(OP_DATA, 8'h01);
  endtask

  task automatic test_length_change_mid_frame();
    configure(32'd10, '1);
    push_item(OP_START, 8'h00);
    repeat (3) push_item(OP_DATA, 8'($urandom()));
    configure(32'd2, '1);
    push_item(OP_DATA, 8'hC3);
  endtask

  task automatic test_random_frames();
    int              n;
    int unsigned     pick;
    int unsigned     count;
    logic [31:0]     len_v;
    logic [31:0]     cap_v;
    longint unsigned total;
    n = 0;
    while (n < RANDOM_ITEMS) begin
      calm = (n >= 120 && n < 190);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        pick = $urandom_range(0, 99);
        if (pick < 50)      len_v = $urandom_range(0, 12);
        else if (pick < 70) len_v = $urandom_range(13, 200);
        else if (pick < 80) len_v = $urandom_range(16380, 16390);
        else                len_v = $urandom();
        total = frame_total(len_v[LEN_W-1:0]);
        pick  = $urandom_range(0, 99);
        if (pick < 60)      cap_v = '1;
        else if (pick < 80) cap_v = 32'(total - $urandom_range(0, 1));
        else if (pick < 90) cap_v = $urandom_range(0, 40);
        else                cap_v = $urandom();
        configure(len_v, cap_v);
      end else if (pick < 40) begin
        wait_drained();
      end
      if ($urandom_range(0, 99) < 80) begin
        push_item(OP_START, 8'($urandom()));
        n++;
        count = (len_reg <= 40) ? len_reg : $urandom_range(1, 40);
        pick  = $urandom_range(0, 99);
        if (pick < 10 && count > 0) count = $urandom_range(0, count - 1);
        else if (pick < 20)         count += $urandom_range(1, 3);
        repeat (count) begin
          push_item(OP_DATA, 8'($urandom()));
          n++;
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          push_item(1'($urandom_range(0, 1)), 8'($urandom()));
          n++;
        end
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_TARGET_LENGTH;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_START;
    len_reg       = '0;
    capacity_reg  = '1;
    frame_open    = 1'b0;
    bytes_passed  = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_zero_length();
    test_pass_through();
    test_varint_widths();
    test_capacity();
    test_restart_open_frame();
    test_length_change_mid_frame();
    test_random_frames();

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (delta_bytes_q.size() != 0) begin
      $error("%0d expected output bytes never arrived", delta_bytes_q.size());
      fail_count++;
    end
    if (fail_count == 0) $display("testbench OK");
    else                 $display("testbench NOT OK");
    $finish;
  end

endmodule
